[src/dcr_pkg.sv]
// Shared types, constants and rounding helper for the distance constraint relaxation block.
package dcr_pkg;

    localparam int COORD_W     = 32;
    localparam int STIFF_W     = 17;
    localparam int STIFF_FRAC  = 16;
    localparam logic [STIFF_W-1:0] STIFF_RESET = 17'h10000;
    localparam int SQRT_STEPS  = 32;
    localparam int NORM_MSB    = 30;

    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic        [31:0] m1;
        logic        [31:0] m2;
        logic        [31:0] len;
        logic        [32:0] msum;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [30:0] na;
        logic        [30:0] nb;
        logic               deg;
    } payload_t;

    // divide by 2^s, nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic signed [63:0] half;
        logic signed [63:0] adj;
        half = 64'sd1 <<< (s - 1);
        adj  = (v < 0) ? 64'sd1 : 64'sd0;
        return (v + half - adj) >>> s;
    endfunction

endpackage

[src/distance_constraint_relax.sv]
// Top level: mass-weighted distance constraint projection pipeline.
// One link correction per clock unless the output stalls. Each beat passes through
// six front stages (difference, normalisation, squares), a 32-stage
// square root, a FRAC_BITS+2 stage divider bank for the unit direction and mass
// shares, then six multiply/round stages ending in the output register. The whole
// pipeline advances together; it halts only while a result sits unclaimed at the
// output, and s_tready follows that. Stiffness is written through the cfg port.
module distance_constraint_relax #(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dcr_pkg::STIFF_W-1:0]   cfg_data,   // stiffness
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // first_x, first_y, first_mass, second_x, second_y, second_mass, rest_length
    input  logic [223:0]                  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // new_first_x, new_first_y, new_second_x, new_second_y
    output logic [127:0]                  m_tdata,
    // degenerate, saturated
    output logic [1:0]                    m_tuser
);
    import dcr_pkg::*;

    localparam int QW   = FRAC_BITS + 2;
    localparam int WW   = FRAC_BITS + 1;
    localparam int NW   = FRAC_BITS + 3;
    localparam int NXW  = 32 + FRAC_BITS;
    localparam int NMW  = 33 + FRAC_BITS;
    localparam int PDW  = 33 + WW + 1;
    localparam int POW  = NW + 33;
    localparam int MCW  = 35;
    localparam int OW   = 36;
    localparam int PQW  = OW + WW + 1;
    localparam int GW   = 38;
    localparam int EW   = GW + STIFF_W + 1;
    localparam int RW   = 40;
    localparam int DL   = SQRT_STEPS + QW;
    localparam int NSTG = 12 + DL;
    localparam logic [WW-1:0] HALF_W = WW'(1) << (FRAC_BITS - 1);

    logic                 en;
    logic [NSTG-1:0]      vld_reg;
    logic [STIFF_W-1:0]   stiff_reg;

    // config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= STIFF_RESET;
        end
        else if (cfg_valid)
        begin
            stiff_reg <= cfg_data;
        end
    end

    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // stage A: input capture
    payload_t pl_a_reg;
    payload_t pl_a_next;

    always_comb
    begin
        pl_a_next     = '0;
        pl_a_next.x1  = s_tdata[31:0];
        pl_a_next.y1  = s_tdata[63:32];
        pl_a_next.m1  = s_tdata[95:64];
        pl_a_next.x2  = s_tdata[127:96];
        pl_a_next.y2  = s_tdata[159:128];
        pl_a_next.m2  = s_tdata[191:160];
        pl_a_next.len = s_tdata[223:192];
    end

    // stage B: differences, magnitudes, mass sum
    payload_t    pl_b_reg;
    payload_t    pl_b_next;
    logic [32:0] ax_b_reg, ay_b_reg;
    logic [32:0] ax_b_next, ay_b_next;

    always_comb
    begin
        pl_b_next      = pl_a_reg;
        pl_b_next.dx   = 33'(pl_a_reg.x2) - 33'(pl_a_reg.x1);
        pl_b_next.dy   = 33'(pl_a_reg.y2) - 33'(pl_a_reg.y1);
        pl_b_next.msum = {1'b0, pl_a_reg.m1} + {1'b0, pl_a_reg.m2};
        pl_b_next.deg  = (pl_b_next.dx == '0) && (pl_b_next.dy == '0);
        ax_b_next      = pl_b_next.dx[32] ? 33'(-pl_b_next.dx) : pl_b_next.dx;
        ay_b_next      = pl_b_next.dy[32] ? 33'(-pl_b_next.dy) : pl_b_next.dy;
    end

    // stage C: leading one of the larger magnitude
    payload_t    pl_c_reg;
    logic [32:0] ax_c_reg, ay_c_reg;
    logic [5:0]  msb_c_reg;
    logic [5:0]  msb_c_next;
    logic [32:0] mx_b;

    always_comb
    begin
        mx_b       = (ax_b_reg > ay_b_reg) ? ax_b_reg : ay_b_reg;
        msb_c_next = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (mx_b[i])
            begin
                msb_c_next = 6'(i);
            end
        end
    end

    // stage D: normalise so the larger lies in [2^30, 2^31)
    payload_t    pl_d_reg;
    payload_t    pl_d_next;
    logic [63:0] wide_x, wide_y;

    always_comb
    begin
        pl_d_next = pl_c_reg;
        if (msb_c_reg > 6'(NORM_MSB))
        begin
            wide_x = {31'b0, ax_c_reg} >> (msb_c_reg - 6'(NORM_MSB));
            wide_y = {31'b0, ay_c_reg} >> (msb_c_reg - 6'(NORM_MSB));
        end
        else
        begin
            wide_x = {31'b0, ax_c_reg} << (6'(NORM_MSB) - msb_c_reg);
            wide_y = {31'b0, ay_c_reg} << (6'(NORM_MSB) - msb_c_reg);
        end
        pl_d_next.na = wide_x[30:0];
        pl_d_next.nb = wide_y[30:0];
    end

    // stage E: squares, stage F: sum
    payload_t    pl_e_reg, pl_f_reg;
    logic [61:0] sqx_e_reg, sqy_e_reg;
    logic [62:0] sum_f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_a_reg  <= pl_a_next;
            pl_b_reg  <= pl_b_next;
            ax_b_reg  <= ax_b_next;
            ay_b_reg  <= ay_b_next;
            pl_c_reg  <= pl_b_reg;
            ax_c_reg  <= ax_b_reg;
            ay_c_reg  <= ay_b_reg;
            msb_c_reg <= msb_c_next;
            pl_d_reg  <= pl_d_next;
            pl_e_reg  <= pl_d_reg;
            sqx_e_reg <= 62'(pl_d_reg.na) * 62'(pl_d_reg.na);
            sqy_e_reg <= 62'(pl_d_reg.nb) * 62'(pl_d_reg.nb);
            pl_f_reg  <= pl_e_reg;
            sum_f_reg <= 63'(sqx_e_reg) + 63'(sqy_e_reg);
        end
    end

    // payload delay alongside square root and dividers
    payload_t pl_dl_reg [DL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_dl_reg[0] <= pl_f_reg;
            for (int j = 1; j < DL; j++)
            begin
                pl_dl_reg[j] <= pl_dl_reg[j-1];
            end
        end
    end

    logic [31:0] root;

    dcr_sqrt u_sqrt
    (
        .clk  (clk),
        .en   (en),
        .rad  (sum_f_reg),
        .root (root)
    );

    payload_t       pl_s;
    logic [NXW-1:0] num_x, num_y;
    logic [NMW-1:0] num_w1, num_w2;
    logic [QW-1:0]  q_x, q_y, q_w1, q_w2;

    assign pl_s   = pl_dl_reg[SQRT_STEPS-1];
    assign num_x  = (NXW'(pl_s.na) << FRAC_BITS) + NXW'(root >> 1);
    assign num_y  = (NXW'(pl_s.nb) << FRAC_BITS) + NXW'(root >> 1);
    assign num_w1 = (NMW'(pl_s.m1) << FRAC_BITS) + NMW'(pl_s.msum >> 1);
    assign num_w2 = (NMW'(pl_s.m2) << FRAC_BITS) + NMW'(pl_s.msum >> 1);

    dcr_div #(.NUM_W(NXW), .DEN_W(32), .QW(QW)) u_div_x
    (
        .clk (clk), .en (en), .num (num_x), .den (root), .quo (q_x)
    );

    dcr_div #(.NUM_W(NXW), .DEN_W(32), .QW(QW)) u_div_y
    (
        .clk (clk), .en (en), .num (num_y), .den (root), .quo (q_y)
    );

    dcr_div #(.NUM_W(NMW), .DEN_W(33), .QW(QW)) u_div_w1
    (
        .clk (clk), .en (en), .num (num_w1), .den (pl_s.msum), .quo (q_w1)
    );

    dcr_div #(.NUM_W(NMW), .DEN_W(33), .QW(QW)) u_div_w2
    (
        .clk (clk), .en (en), .num (num_w2), .den (pl_s.msum), .quo (q_w2)
    );

    // stage G: signed direction, shares, first products
    payload_t               pl_q;
    logic signed [NW-1:0]   nx_q, ny_q;
    logic        [WW-1:0]   w1_q, w2_q;

    assign pl_q = pl_dl_reg[DL-1];
    assign nx_q = pl_q.dx[32] ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
    assign ny_q = pl_q.dy[32] ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
    assign w1_q = (pl_q.msum == '0) ? HALF_W : q_w1[WW-1:0];
    assign w2_q = (pl_q.msum == '0) ? HALF_W : q_w2[WW-1:0];

    payload_t               pl_g_reg;
    logic        [WW-1:0]   w1_g_reg, w2_g_reg;
    logic signed [PDW-1:0]  pdx_g_reg, pdy_g_reg;
    logic signed [POW-1:0]  pox_g_reg, poy_g_reg;

    // stage H: mass centre and offset
    payload_t               pl_h_reg;
    logic        [WW-1:0]   w1_h_reg, w2_h_reg;
    logic signed [MCW-1:0]  mcx_h_reg, mcy_h_reg;
    logic signed [OW-1:0]   ox_h_reg, oy_h_reg;

    // stage I: offset times shares
    payload_t               pl_i_reg;
    logic signed [MCW-1:0]  mcx_i_reg, mcy_i_reg;
    logic signed [PQW-1:0]  qx1_i_reg, qy1_i_reg, qx2_i_reg, qy2_i_reg;

    // stage J: goals minus positions
    payload_t               pl_j_reg;
    logic signed [GW-1:0]   d1x_j_reg, d1y_j_reg, d2x_j_reg, d2y_j_reg;
    logic signed [GW-1:0]   g1x, g1y, g2x, g2y;

    assign g1x = GW'(mcx_i_reg) - GW'(rnd_shift(64'(qx2_i_reg), FRAC_BITS));
    assign g1y = GW'(mcy_i_reg) - GW'(rnd_shift(64'(qy2_i_reg), FRAC_BITS));
    assign g2x = GW'(mcx_i_reg) + GW'(rnd_shift(64'(qx1_i_reg), FRAC_BITS));
    assign g2y = GW'(mcy_i_reg) + GW'(rnd_shift(64'(qy1_i_reg), FRAC_BITS));

    // stage K: stiffness products
    payload_t               pl_k_reg;
    logic signed [EW-1:0]   e1x_k_reg, e1y_k_reg, e2x_k_reg, e2y_k_reg;
    logic signed [STIFF_W:0] kk;

    assign kk = $signed({1'b0, stiff_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_g_reg  <= pl_q;
            w1_g_reg  <= w1_q;
            w2_g_reg  <= w2_q;
            pdx_g_reg <= PDW'(pl_q.dx) * PDW'($signed({1'b0, w2_q}));
            pdy_g_reg <= PDW'(pl_q.dy) * PDW'($signed({1'b0, w2_q}));
            pox_g_reg <= POW'(nx_q) * POW'($signed({1'b0, pl_q.len}));
            poy_g_reg <= POW'(ny_q) * POW'($signed({1'b0, pl_q.len}));

            pl_h_reg  <= pl_g_reg;
            w1_h_reg  <= w1_g_reg;
            w2_h_reg  <= w2_g_reg;
            mcx_h_reg <= MCW'(pl_g_reg.x1) + MCW'(rnd_shift(64'(pdx_g_reg), FRAC_BITS));
            mcy_h_reg <= MCW'(pl_g_reg.y1) + MCW'(rnd_shift(64'(pdy_g_reg), FRAC_BITS));
            ox_h_reg  <= OW'(rnd_shift(64'(pox_g_reg), FRAC_BITS));
            oy_h_reg  <= OW'(rnd_shift(64'(poy_g_reg), FRAC_BITS));

            pl_i_reg  <= pl_h_reg;
            mcx_i_reg <= mcx_h_reg;
            mcy_i_reg <= mcy_h_reg;
            qx1_i_reg <= PQW'(ox_h_reg) * PQW'($signed({1'b0, w1_h_reg}));
            qy1_i_reg <= PQW'(oy_h_reg) * PQW'($signed({1'b0, w1_h_reg}));
            qx2_i_reg <= PQW'(ox_h_reg) * PQW'($signed({1'b0, w2_h_reg}));
            qy2_i_reg <= PQW'(oy_h_reg) * PQW'($signed({1'b0, w2_h_reg}));

            pl_j_reg  <= pl_i_reg;
            d1x_j_reg <= g1x - GW'(pl_i_reg.x1);
            d1y_j_reg <= g1y - GW'(pl_i_reg.y1);
            d2x_j_reg <= g2x - GW'(pl_i_reg.x2);
            d2y_j_reg <= g2y - GW'(pl_i_reg.y2);

            pl_k_reg  <= pl_j_reg;
            e1x_k_reg <= EW'(d1x_j_reg) * EW'(kk);
            e1y_k_reg <= EW'(d1y_j_reg) * EW'(kk);
            e2x_k_reg <= EW'(d2x_j_reg) * EW'(kk);
            e2y_k_reg <= EW'(d2y_j_reg) * EW'(kk);
        end
    end

    // output stage: final add, clip, pass-through on coincident points
    logic signed [RW-1:0] r1x, r1y, r2x, r2y;
    logic [31:0]          c1x, c1y, c2x, c2y;
    logic                 clip;
    logic [127:0]         tdata_next;
    logic [1:0]           tuser_next;
    logic [127:0]         m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    function automatic logic [31:0] sat32(input logic signed [RW-1:0] v);
        if (v > RW'(64'sd2147483647))
        begin
            return 32'h7FFF_FFFF;
        end
        else if (v < -RW'(64'sd2147483648))
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic out_of_range(input logic signed [RW-1:0] v);
        return (v > RW'(64'sd2147483647)) || (v < -RW'(64'sd2147483648));
    endfunction

    always_comb
    begin
        r1x = RW'(pl_k_reg.x1) + RW'(rnd_shift(64'(e1x_k_reg), STIFF_FRAC));
        r1y = RW'(pl_k_reg.y1) + RW'(rnd_shift(64'(e1y_k_reg), STIFF_FRAC));
        r2x = RW'(pl_k_reg.x2) + RW'(rnd_shift(64'(e2x_k_reg), STIFF_FRAC));
        r2y = RW'(pl_k_reg.y2) + RW'(rnd_shift(64'(e2y_k_reg), STIFF_FRAC));
        c1x = sat32(r1x);
        c1y = sat32(r1y);
        c2x = sat32(r2x);
        c2y = sat32(r2y);
        clip = out_of_range(r1x) || out_of_range(r1y)
            || out_of_range(r2x) || out_of_range(r2y);
        if (pl_k_reg.deg)
        begin
            tdata_next = {pl_k_reg.y2, pl_k_reg.x2, pl_k_reg.y1, pl_k_reg.x1};
            tuser_next = 2'b01;
        end
        else
        begin
            tdata_next = {c2y, c2x, c1y, c1x};
            tuser_next = {clip, 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= tuser_next;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    a_deg_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
        else $error("degenerate beat flagged as saturated");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[NSTG-2]) |=> m_tvalid)
        else $error("beat lost at output stage");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule

[src/dcr_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module dcr_sqrt
(
    input  logic        clk,
    input  logic        en,
    input  logic [62:0] rad,
    output logic [31:0] root
);
    import dcr_pkg::*;

    logic [63:0] rem_reg [SQRT_STEPS-1];
    logic [63:0] res_reg [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_step
        localparam logic [63:0] BITC = 64'd1 << (62 - 2 * s);
        logic [63:0] rin;
        logic [63:0] resin;
        logic [63:0] t;
        logic        ge;

        if (s == 0)
        begin : g_first
            assign rin   = {1'b0, rad};
            assign resin = '0;
        end
        else
        begin : g_rest
            assign rin   = rem_reg[s-1];
            assign resin = res_reg[s-1];
        end

        assign t  = resin + BITC;
        assign ge = (rin >= t);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[s] <= ge ? ((resin >> 1) + BITC) : (resin >> 1);
            end
        end

        if (s < SQRT_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= ge ? (rin - t) : rin;
                end
            end
        end
    end

    assign root = res_reg[SQRT_STEPS-1][31:0];

endmodule

[src/dcr_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module dcr_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int QW    = 18
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QW-1:0]    quo
);
    localparam int CW = DEN_W + QW;

    logic [CW-1:0]    rem_reg [QW-1];
    logic [DEN_W-1:0] den_reg [QW-1];
    logic [QW-1:0]    quo_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_step
        localparam int SH = QW - 1 - s;
        logic [CW-1:0]    rin;
        logic [CW-1:0]    sub;
        logic [DEN_W-1:0] din;
        logic [QW-1:0]    qin;
        logic             ge;

        if (s == 0)
        begin : g_first
            assign rin = CW'(num);
            assign din = den;
            assign qin = '0;
        end
        else
        begin : g_rest
            assign rin = rem_reg[s-1];
            assign din = den_reg[s-1];
            assign qin = quo_reg[s-1];
        end

        assign sub = CW'(din) << SH;
        assign ge  = (rin >= sub);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= ge ? (qin | (QW'(1) << SH)) : qin;
            end
        end

        if (s < QW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= ge ? (rin - sub) : rin;
                    den_reg[s] <= din;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

[tb/sv/tb_distance_constraint_relax.sv]
// Testbench for the distance constraint relaxation pipeline: directed and random links, scoreboard.
module tb_distance_constraint_relax;
    import dcr_pkg::*;

    localparam int FB      = 16;
    localparam int LATENCY = 45 + FB;

    typedef struct {
        logic signed [31:0] x1, y1;
        logic        [31:0] m1;
        logic signed [31:0] x2, y2;
        logic        [31:0] m2;
        logic        [31:0] len;
    } link_t;

    typedef struct {
        logic [127:0] pos;
        logic [1:0]   flags;
    } fix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [STIFF_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [223:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0] m_tuser;

    distance_constraint_relax #(.FRAC_BITS(FB)) DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    link_t  pending_links[$];
    fix_t   expected_fixes[$];
    logic [16:0] stiff_model = 17'h10000;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int n_bad = 0;
    int n_fixes = 0;
    int n_links = 0;
    int n_degen = 0;
    int n_clip = 0;

    function automatic longint rshift(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clip32(longint v, ref bit clipped);
        if (v > 64'sd2147483647)
        begin
            clipped = 1'b1;
            v = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            clipped = 1'b1;
            v = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    function automatic fix_t relax_link(link_t l, logic [16:0] k_reg);
        fix_t f;
        longint x1, y1, x2, y2, dx, dy, k, len, nx, ny, mcx, mcy, ox, oy;
        longint g1x, g1y, g2x, g2y;
        longint unsigned ax, ay, mx, msum, w1, w2, sl;
        bit clipped;
        x1 = l.x1; y1 = l.y1; x2 = l.x2; y2 = l.y2;
        len = {32'd0, l.len};
        k = {47'd0, k_reg};
        dx = x2 - x1;
        dy = y2 - y1;
        clipped = 1'b0;
        if (dx == 0 && dy == 0)
        begin
            f.pos = {l.y2, l.x2, l.y1, l.x1};
            f.flags = 2'b01;
            return f;
        end
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        mx = (ax > ay) ? ax : ay;
        while (mx >= (64'd1 << 31))
        begin
            ax >>= 1; ay >>= 1; mx >>= 1;
        end
        while (mx < (64'd1 << 30))
        begin
            ax <<= 1; ay <<= 1; mx <<= 1;
        end
        sl = isqrt(ax * ax + ay * ay);
        nx = ((ax << FB) + sl / 2) / sl;
        ny = ((ay << FB) + sl / 2) / sl;
        if (dx < 0) nx = -nx;
        if (dy < 0) ny = -ny;
        msum = {32'd0, l.m1} + {32'd0, l.m2};
        if (msum == 0)
        begin
            w1 = 64'd1 << (FB - 1);
            w2 = w1;
        end
        else
        begin
            w1 = (({32'd0, l.m1} << FB) + msum / 2) / msum;
            w2 = (({32'd0, l.m2} << FB) + msum / 2) / msum;
        end
        mcx = x1 + rshift(dx * longint'(w2), FB);
        mcy = y1 + rshift(dy * longint'(w2), FB);
        ox = rshift(nx * len, FB);
        oy = rshift(ny * len, FB);
        g1x = mcx - rshift(ox * longint'(w2), FB);
        g1y = mcy - rshift(oy * longint'(w2), FB);
        g2x = mcx + rshift(ox * longint'(w1), FB);
        g2y = mcy + rshift(oy * longint'(w1), FB);
        f.pos[31:0]   = clip32(x1 + rshift((g1x - x1) * k, STIFF_FRAC), clipped);
        f.pos[63:32]  = clip32(y1 + rshift((g1y - y1) * k, STIFF_FRAC), clipped);
        f.pos[95:64]  = clip32(x2 + rshift((g2x - x2) * k, STIFF_FRAC), clipped);
        f.pos[127:96] = clip32(y2 + rshift((g2y - y2) * k, STIFF_FRAC), clipped);
        f.flags = {clipped, 1'b0};
        return f;
    endfunction

    function automatic void add_link(link_t l);
        pending_links = {pending_links, l};
    endfunction

    // driver
    always @(posedge clk)
    begin
        link_t l;
        if (rst_n)
        begin
            if (!s_tvalid || s_tready)
            begin
                if (pending_links.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    l = pending_links.pop_front();
                    s_tdata <= {l.len, l.m2, l.y2, l.x2, l.m1, l.y1, l.x1};
                    s_tvalid <= 1'b1;
                    expected_fixes = {expected_fixes, relax_link(l, stiff_model)};
                    n_links++;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver hold-off counter
    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // monitor
    always @(posedge clk)
    begin
        fix_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_fixes++;
                if (expected_fixes.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected beat %h %b", m_tdata, m_tuser);
                end
                else
                begin
                    e = expected_fixes.pop_front();
                    if (e.flags[0]) n_degen++;
                    if (e.flags[1]) n_clip++;
                    if (m_tdata !== e.pos || m_tuser !== e.flags)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("mismatch: exp %h %b got %h %b",
                                     e.pos, e.flags, m_tdata, m_tuser);
                    end
                end
            end
            m_tready <= (hold_off <= 1) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(2) == 0 ? 32'h7fffffff - $urandom_range(4096)
                                             : 32'h80000000 + $urandom_range(4096);
            default: return $urandom_range(2000000) - 1000000;
        endcase
    endfunction

    function automatic link_t rnd_link();
        link_t l;
        l.x1 = rnd_coord();
        l.y1 = rnd_coord();
        l.x2 = ($urandom_range(19) == 0) ? l.x1 : l.x1 + $signed($urandom_range(400000)) - 200000;
        l.y2 = ($urandom_range(19) == 0) ? l.y1 : rnd_coord();
        if ($urandom_range(3) == 0) l.x2 = rnd_coord();
        l.m1 = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1 << 20);
        l.m2 = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1 << 20);
        if ($urandom_range(30) == 0) l.m1 = 0;
        if ($urandom_range(30) == 0) l.m2 = 0;
        l.len = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1 << 22);
        return l;
    endfunction

    function automatic link_t mk(int x1, int y1, int m1, int x2, int y2, int m2, int len);
        link_t l;
        l.x1 = x1; l.y1 = y1; l.m1 = m1; l.x2 = x2; l.y2 = y2; l.m2 = m2; l.len = len;
        return l;
    endfunction

    task automatic drain();
        while (pending_links.size() != 0 || expected_fixes.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic set_stiffness(logic [16:0] k);
        @(posedge clk);
        cfg_data <= k;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        stiff_model = k;
    endtask

    task automatic random_phase(int n);
        repeat (n) add_link(rnd_link());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // sender idles a little, receiver mostly
        send_idle_pct = 7; recv_idle_pct = 82;
        add_link(mk(0, 0, 65536, 65536, 0, 65536, 131072));
        add_link(mk(100, 200, 1, 100, 200, 5, 9));
        add_link(mk(32'h80000000, 32'h80000000, 32'hffffffff,
                    32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff));
        add_link(mk(32'h7fffffff, 0, 0, 32'h80000000, 5, 0, 32'hffffffff));
        add_link(mk(0, 0, 0, 1, 1, 65536, 0));
        add_link(mk(0, 0, 65536, 0, -1, 0, 65536));
        add_link(mk(-5, 7, 1, 3, 7, 1, 32'hffffffff));
        add_link(mk(32'h7fffffff, 32'h7fffffff, 2, 32'h7ffffff0, 32'h7fffffff,
                    3, 32'h10000000));
        add_link(mk(-1, -1, 32'hffffffff, -1, -1, 1, 0));
        add_link(mk(0, 0, 32'hffffffff, 1, 0, 1, 32'hffffffff));
        drain();
        // long receiver hold-off while the sender keeps offering
        hold_off = 400;
        random_phase(120);
        drain();
        random_phase(450);
        drain();
        set_stiffness(17'h0);
        send_idle_pct = 82; recv_idle_pct = 7;
        random_phase(300);
        drain();
        set_stiffness(17'h1ffff);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(300);
        drain();
        set_stiffness(17'h08000);
        random_phase(400);
        drain();
        set_stiffness(17'h10000);
        random_phase(370);
        drain();
        $display("covered %0d links, %0d results (%0d coincident, %0d clipped)",
                 n_links, n_fixes, n_degen, n_clip);
        $display("stiffness swept over zero, half, full and the top of the register");
        if (n_bad == 0 && expected_fixes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
src/dcr_pkg.sv
src/dcr_sqrt.sv
src/dcr_div.sv
src/distance_constraint_relax.sv
tb/sv/tb_distance_constraint_relax.sv
